/* rtl/core/rfs_pkg.sv */
package rfs_pkg;

  // sprite geometry
  localparam int SPRITE_SIZE = 32;
  localparam int COORD_W     = 5;

  // fixed point formats
  localparam int FRAC_W      = 16;
  localparam int FRAC_ONE    = 1 << FRAC_W;
  localparam int A_W         = FRAC_W + 1;
  localparam int COEF_BASE   = 36045;
  localparam int COEF_RIM    = 29491;
  localparam int ALPHA_W     = 8;
  localparam int ALPHA_SCALE = 255;
  localparam int TINT_W      = 8;
  localparam int WORD_W      = 4 * TINT_W;

  // stream packing
  localparam int IN_DATA_W   = ((2 * COORD_W + 7) / 8) * 8;

  // centered coordinate, its square and the disc limit
  localparam int U_W         = $clog2((2 << COORD_W) + SPRITE_SIZE) + 1;
  localparam int S_WIDE_W    = 2 * U_W + 1;
  localparam int DISC_LIM    = SPRITE_SIZE * SPRITE_SIZE;
  localparam int SQ_W        = $clog2(DISC_LIM);

  // root extraction of s * 2^(2*FRAC_W)
  localparam int ROOT_W      = $clog2(SPRITE_SIZE * FRAC_ONE);
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 3;
  localparam int ROOT_STEPS  = 3;
  localparam int ROOT_STAGES = (ROOT_W + ROOT_STEPS - 1) / ROOT_STEPS;

  // configuration register indexes
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TINT_BLUE  = 2'd2;

  typedef struct packed {
    logic [SQ_W-1:0] s;
    logic            covered;
  } dist_req_t;

  typedef struct packed {
    logic [ROOT_W-1:0] root;
    logic              covered;
  } root_req_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              covered;
  } root_work_t;

  typedef struct packed {
    logic [TINT_W-1:0] red;
    logic [TINT_W-1:0] green;
    logic [TINT_W-1:0] blue;
  } tint_t;

  // a few digit steps of the bit-pair square root
  function automatic root_work_t root_steps(root_work_t cur, int base);
    root_work_t       nxt;
    logic [REM_W-1:0] trial;
    nxt = cur;
    for (int k = 0; k < ROOT_STEPS; k++) begin
      if (base + k < ROOT_W) begin
        nxt.rem = {nxt.rem[REM_W-3:0], nxt.rad[RAD_W-1 -: 2]};
        nxt.rad = {nxt.rad[RAD_W-3:0], 2'b00};
        trial = {{(REM_W-ROOT_W-2){1'b0}}, nxt.root, 2'b01};
        if (nxt.rem >= trial) begin
          nxt.rem  = nxt.rem - trial;
          nxt.root = {nxt.root[ROOT_W-2:0], 1'b1};
        end else begin
          nxt.root = {nxt.root[ROOT_W-2:0], 1'b0};
        end
      end
    end
    return nxt;
  endfunction

endpackage

/* rtl/core/rfs_dist.sv */
module rfs_dist (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rfs_pkg::COORD_W-1:0] in_col,
  input  logic [rfs_pkg::COORD_W-1:0] in_row,
  output logic                     out_valid,
  input  logic                     out_ready,
  output rfs_pkg::dist_req_t       out_req
);
  import rfs_pkg::*;

  logic signed [U_W-1:0]   u;
  logic signed [U_W-1:0]   v;
  logic [2*U_W-1:0]        usq;
  logic [2*U_W-1:0]        vsq;
  logic [S_WIDE_W-1:0]     s_wide;
  logic                    in_disc;

  always_comb begin
    u       = $signed({{(U_W-COORD_W-1){1'b0}}, in_col, 1'b1}) - U_W'(SPRITE_SIZE);
    v       = $signed({{(U_W-COORD_W-1){1'b0}}, in_row, 1'b1}) - U_W'(SPRITE_SIZE);
    usq     = u * u;
    vsq     = v * v;
    s_wide  = {1'b0, usq} + {1'b0, vsq};
    in_disc = s_wide < S_WIDE_W'(DISC_LIM);
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // outside pixels feed zero into the root so the root stays in range
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_req.covered <= in_disc;
      out_req.s       <= in_disc ? s_wide[SQ_W-1:0] : '0;
    end
  end

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_req.covered) |-> (out_req.s == '0))
    else $error("outside pixel carries a nonzero distance");

endmodule

/* rtl/core/rfs_root.sv */
module rfs_root (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rfs_pkg::dist_req_t in_req,
  output logic               out_valid,
  input  logic               out_ready,
  output rfs_pkg::root_req_t out_req
);
  import rfs_pkg::*;

  // incoming request, then one entry per stage register
  root_work_t work_in;
  logic       vld  [ROOT_STAGES];
  root_work_t work [ROOT_STAGES];
  logic       rdy  [ROOT_STAGES+1];

  assign work_in.rad     = RAD_W'({in_req.s, {(2*FRAC_W){1'b0}}});
  assign work_in.rem     = '0;
  assign work_in.root    = '0;
  assign work_in.covered = in_req.covered;
  assign rdy[ROOT_STAGES] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_stage
    logic       prev_vld;
    root_work_t prev_work;

    if (g == 0) begin : g_first
      assign prev_vld  = in_valid;
      assign prev_work = work_in;
    end else begin : g_next
      assign prev_vld  = vld[g-1];
      assign prev_work = work[g-1];
    end

    assign rdy[g] = !vld[g] || rdy[g+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (rdy[g]) begin
        vld[g] <= prev_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (prev_vld && rdy[g]) begin
        work[g] <= root_steps(prev_work, g * ROOT_STEPS);
      end
    end
  end

  assign out_valid       = vld[ROOT_STAGES-1];
  assign out_req.root    = work[ROOT_STAGES-1].root;
  assign out_req.covered = work[ROOT_STAGES-1].covered;

  a_root_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((ROOT_W+1)'(out_req.root) < (ROOT_W+1)'(SPRITE_SIZE * FRAC_ONE)))
    else $error("root reaches the disc radius");

  a_root_outside: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_req.covered) |-> (out_req.root == '0))
    else $error("outside pixel has a nonzero root");

endmodule

/* rtl/core/rfs_shade.sv */
module rfs_shade (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  rfs_pkg::root_req_t         in_req,
  input  rfs_pkg::tint_t             tint,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rfs_pkg::WORD_W-1:0] m_tdata,
  output logic                       m_tuser
);
  import rfs_pkg::*;

  // stage a: distance and its complement
  logic              a_vld;
  logic [FRAC_W-1:0] a_d;
  logic [A_W-1:0]    a_a;
  logic              a_cov;
  // stage b: squared complement and rim factor
  logic              b_vld;
  logic [A_W-1:0]    b_a2;
  logic [FRAC_W-1:0] b_f;
  logic              b_cov;
  // stage c: falloff product
  logic              c_vld;
  logic [FRAC_W-1:0] c_p;
  logic              c_cov;

  logic                 a_rdy, b_rdy, c_rdy, o_rdy;
  logic [FRAC_W-1:0]    d_next;
  logic [2*A_W-1:0]     prod_aa;
  logic [2*FRAC_W-1:0]  prod_rim;
  logic [A_W+FRAC_W-1:0] prod_af;
  logic [ALPHA_W+FRAC_W-1:0] prod_alpha;
  logic [ALPHA_W-1:0]   alpha;

  assign o_rdy    = !m_tvalid || m_tready;
  assign c_rdy    = !c_vld || o_rdy;
  assign b_rdy    = !b_vld || c_rdy;
  assign a_rdy    = !a_vld || b_rdy;
  assign in_ready = a_rdy;

  always_comb begin
    d_next     = FRAC_W'(in_req.root / ROOT_W'(SPRITE_SIZE));
    prod_aa    = a_a * a_a;
    prod_rim   = FRAC_W'(COEF_RIM) * a_d;
    prod_af    = b_a2 * b_f;
    prod_alpha = ALPHA_W'(ALPHA_SCALE) * c_p;
    alpha      = prod_alpha[FRAC_W +: ALPHA_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      c_vld    <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (a_rdy) a_vld <= in_valid;
      if (b_rdy) b_vld <= a_vld;
      if (c_rdy) c_vld <= b_vld;
      if (o_rdy) m_tvalid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && a_rdy) begin
      a_d   <= d_next;
      a_a   <= A_W'(FRAC_ONE) - A_W'(d_next);
      a_cov <= in_req.covered;
    end
    if (a_vld && b_rdy) begin
      b_a2  <= prod_aa[FRAC_W +: A_W];
      b_f   <= FRAC_W'(COEF_BASE) + prod_rim[FRAC_W +: FRAC_W];
      b_cov <= a_cov;
    end
    if (b_vld && c_rdy) begin
      c_p   <= prod_af[FRAC_W +: FRAC_W];
      c_cov <= b_cov;
    end
    if (c_vld && o_rdy) begin
      m_tdata <= c_cov ? {tint.red, tint.green, tint.blue, alpha} : '0;
      m_tuser <= c_cov;
    end
  end

  a_outside_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("outside pixel gives a nonzero word");

  a_alpha_max: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[ALPHA_W-1:0] != {ALPHA_W{1'b1}}))
    else $error("alpha reached full scale");

endmodule

/* rtl/core/radial_falloff_sprite_pixel.sv */
// channel   direction  handshake           payload
// s_*       in         s_tvalid/s_tready   tdata: pixel_col, pixel_row
// m_*       out        m_tvalid/m_tready   tdata: pixel_word; tuser: covered
// cfg_*     in         cfg_we              cfg_index, cfg_data (tint bytes)
//
// one request per cycle while m_tready holds; stages from input to output: 1 distance stage,
// 7 root stages (3 digits of the 21-bit square root each), 4 shading stages
// rst is synchronous, active high; it clears the valid bits and the tints
// each stage holds while its successor is full, and takes a new request as
// soon as it empties, so bubbles close up and stalls drop or repeat nothing
// tints are read at the output register; change them only when idle, the block itself does not enforce it
module radial_falloff_sprite_pixel (
  input  logic                          clk,
  input  logic                          rst,
  // slave side: pixel_col [4:0], pixel_row [9:5], zeros above
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rfs_pkg::IN_DATA_W-1:0] s_tdata,
  // master side: pixel_word [31:0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rfs_pkg::WORD_W-1:0]    m_tdata,
  // covered [0]
  output logic                          m_tuser,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [rfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfs_pkg::TINT_W-1:0]    cfg_data
);
  import rfs_pkg::*;

  tint_t     tint;
  logic      dist_valid, dist_ready;
  dist_req_t dist_req;
  logic      root_valid, root_ready;
  root_req_t root_req;

  // tint registers, indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      tint <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TINT_RED:   tint.red   <= cfg_data;
        REG_TINT_GREEN: tint.green <= cfg_data;
        REG_TINT_BLUE:  tint.blue  <= cfg_data;
        default: ;
      endcase
    end
  end

  // centered coordinates, squared radius and disc test
  rfs_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_col    (s_tdata[COORD_W-1:0]),
    .in_row    (s_tdata[2*COORD_W-1:COORD_W]),
    .out_valid (dist_valid),
    .out_ready (dist_ready),
    .out_req   (dist_req)
  );

  // pipelined square root of the squared radius in q.16
  rfs_root u_root (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dist_valid),
    .in_ready  (dist_ready),
    .in_req    (dist_req),
    .out_valid (root_valid),
    .out_ready (root_ready),
    .out_req   (root_req)
  );

  // falloff products, alpha and output register
  rfs_shade u_shade (
    .clk      (clk),
    .rst      (rst),
    .in_valid (root_valid),
    .in_ready (root_ready),
    .in_req   (root_req),
    .tint     (tint),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

/* verif/tb_radial_falloff_sprite_pixel.sv */
`timescale 1ns / 100ps

module tb_radial_falloff_sprite_pixel;
  import rfs_pkg::*;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  localparam int LATENCY_SLACK = 16;   // pipeline is 12 deep, the slack is larger than its depth
  localparam int HOLD_CYCLES   = 300;  // long output stall, fills the pipe
  localparam int GAP_PERCENT   = 7;

  // one expected output beat
  typedef struct packed {
    logic [WORD_W-1:0] pixel_word;
    logic              covered;
  } pixel_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [WORD_W-1:0]    m_tdata;
  logic                 m_tuser;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TINT_RED;
  logic [TINT_W-1:0]    cfg_data = '0;

  // shadow of the tint registers, reset value is all zero
  tint_t         tint_shadow = '0;
  // results still owed by the block, oldest first
  pixel_result_t awaited_pixels[$];

  bit   send_gaps_on  = 1'b1;
  logic ready_gaps_on = 1'b1;
  logic hold_active   = 1'b0;
  event hold_off_ev;

  int mismatch_count = 0;
  int pixels_sent    = 0;
  int pixels_checked = 0;
  int covered_seen   = 0;
  int tint_writes    = 0;

  radial_falloff_sprite_pixel uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the pipeline hangs
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // expected shading of one pixel: distance from the sprite center in Q0.16,
  // quadratic falloff times a rim boost, scaled to an alpha byte
  function automatic pixel_result_t shade_pixel(input logic [COORD_W-1:0] col,
                                                input logic [COORD_W-1:0] row,
                                                input tint_t tint);
    pixel_result_t     res;
    int                u;
    int                v;
    longint unsigned   dist_sq;
    longint unsigned   radicand;
    longint unsigned   root;
    longint unsigned   trial;
    longint unsigned   frac_d;
    longint unsigned   falloff;
    longint unsigned   falloff_sq;
    longint unsigned   rim_gain;
    longint unsigned   shade;
    longint unsigned   alpha;
    // centered coordinates at twice the pixel pitch, so centers are odd
    u = 2 * int'(col) + 1 - SPRITE_SIZE;
    v = 2 * int'(row) + 1 - SPRITE_SIZE;
    dist_sq = longint'(u * u + v * v);
    res = '0;
    if (dist_sq >= DISC_LIM) begin
      return res;
    end
    // floor(sqrt(dist_sq * 2^32)) by greedy bit setting from the top
    radicand = dist_sq << 32;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= radicand) begin
        root = trial;
      end
    end
    frac_d = root / SPRITE_SIZE;
    if (frac_d >= FRAC_ONE) begin
      frac_d = FRAC_ONE - 1;
    end
    falloff    = FRAC_ONE - frac_d;
    falloff_sq = (falloff * falloff) >> FRAC_W;
    rim_gain   = COEF_BASE + ((COEF_RIM * frac_d) >> FRAC_W);
    shade      = (falloff_sq * rim_gain) >> FRAC_W;
    alpha      = (ALPHA_SCALE * shade) >> FRAC_W;
    if (alpha > 255) begin
      alpha = 255;
    end
    res.pixel_word = {tint.red, tint.green, tint.blue, alpha[ALPHA_W-1:0]};
    res.covered    = 1'b1;
    return res;
  endfunction

  // output side ready: random gaps, or held low for a long stretch
  always @(posedge clk) begin
    if (hold_active) begin
      m_tready <= 1'b0;
    end else if (ready_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // long output stall, counted here so the sender keeps pushing meanwhile
  initial begin
    forever begin
      @(hold_off_ev);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // compare every accepted output beat against the oldest awaited result
  always @(posedge clk) begin
    pixel_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_pixels.size() == 0) begin
        $error("unexpected output beat: pixel_word %h covered %b", m_tdata, m_tuser);
        mismatch_count++;
      end else begin
        want = awaited_pixels.pop_front();
        if (m_tdata !== want.pixel_word) begin
          $error("pixel_word expected %h got %h", want.pixel_word, m_tdata);
          mismatch_count++;
        end
        if (m_tuser !== want.covered) begin
          $error("covered expected %b got %b", want.covered, m_tuser);
          mismatch_count++;
        end
        pixels_checked++;
        if (want.covered) begin
          covered_seen++;
        end
      end
    end
  end

  // offer one pixel request and hold it until the block takes it
  task automatic push_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
    while (send_gaps_on && $urandom_range(99) < GAP_PERCENT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - 2 * COORD_W){1'b0}}, row, col};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    awaited_pixels.push_back(shade_pixel(col, row, tint_shadow));
    pixels_sent++;
  endtask

  task automatic push_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      push_pixel(COORD_W'($urandom_range(SPRITE_SIZE - 1)),
                 COORD_W'($urandom_range(SPRITE_SIZE - 1)));
    end
  endtask

  // stop sending and wait until every owed result is out, pipe then empty
  task automatic drain_pixels();
    s_tvalid <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY_SLACK) @(posedge clk);
  endtask

  // register write, only issued while the pipe is empty
  task automatic write_tint(input logic [CFG_IDX_W-1:0] idx, input logic [TINT_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_TINT_RED:   tint_shadow.red   = val;
      REG_TINT_GREEN: tint_shadow.green = val;
      REG_TINT_BLUE:  tint_shadow.blue  = val;
      default: ;
    endcase
    tint_writes++;
    @(posedge clk);
  endtask

  task automatic write_all_tints(input logic [TINT_W-1:0] red, input logic [TINT_W-1:0] green,
                                 input logic [TINT_W-1:0] blue);
    write_tint(REG_TINT_RED, red);
    write_tint(REG_TINT_GREEN, green);
    write_tint(REG_TINT_BLUE, blue);
  endtask

  // random value for all three tints
  task automatic write_random_tints();
    write_all_tints(TINT_W'($urandom_range(255)), TINT_W'($urandom_range(255)),
                    TINT_W'($urandom_range(255)));
  endtask

  // corners, the four center pixels, edge midpoints and pixels right at the rim,
  // with the tints still at their reset value
  task automatic test_directed_pixels();
    push_pixel(0, 0);    push_pixel(31, 31);  push_pixel(0, 31);   push_pixel(31, 0);
    push_pixel(15, 15);  push_pixel(16, 16);  push_pixel(15, 16);  push_pixel(16, 15);
    push_pixel(0, 15);   push_pixel(31, 16);  push_pixel(15, 0);   push_pixel(16, 31);
    // just inside and just outside the disc, and three pixels well off the rim
    push_pixel(0, 12);   push_pixel(0, 11);   push_pixel(12, 0);   push_pixel(31, 19);
    push_pixel(31, 20);  push_pixel(1, 1);    push_pixel(30, 30);  push_pixel(21, 10);
    drain_pixels();
  endtask

  // each register at all ones and at alternating bit patterns, red and blue also at zero,
  // plus two writes to the unused index that must leave the tints alone
  task automatic test_tint_registers();
    write_all_tints(8'hFF, 8'hFF, 8'hFF);
    push_pixel(15, 15); push_pixel(3, 9); push_pixel(0, 0); push_pixel(20, 27);
    drain_pixels();
    write_all_tints(8'hA5, 8'h5A, 8'hC3);
    push_pixel(16, 15); push_pixel(8, 22); push_pixel(31, 31); push_pixel(27, 4);
    drain_pixels();
    write_tint(REG_NONE, 8'hFF);
    write_all_tints(8'h5A, 8'hA5, 8'h3C);
    write_tint(REG_NONE, 8'h00);
    push_pixel(15, 16); push_pixel(10, 10); push_pixel(0, 16); push_pixel(25, 18);
    drain_pixels();
    // same register written three times, last one wins
    write_tint(REG_TINT_GREEN, 8'h0F);
    write_tint(REG_TINT_GREEN, 8'hF0);
    write_all_tints(8'h00, 8'hF0, 8'h00);
    push_pixel(14, 17); push_pixel(5, 26); push_pixel(31, 0); push_pixel(19, 12);
    drain_pixels();
  endtask

  // one whole sprite in raster order
  task automatic test_raster_frame();
    write_random_tints();
    for (int row = 0; row < SPRITE_SIZE; row++) begin
      for (int col = 0; col < SPRITE_SIZE; col++) begin
        push_pixel(COORD_W'(col), COORD_W'(row));
      end
    end
    drain_pixels();
  endtask

  // no gaps on either side, full rate through the pipe
  task automatic test_back_to_back();
    write_random_tints();
    send_gaps_on = 1'b0;
    ready_gaps_on <= 1'b0;
    push_random_pixels(150);
    drain_pixels();
    send_gaps_on = 1'b1;
    ready_gaps_on <= 1'b1;
  endtask

  // output held off while requests keep coming, input must back up
  task automatic test_output_hold();
    write_random_tints();
    send_gaps_on = 1'b0;
    -> hold_off_ev;
    push_random_pixels(120);
    send_gaps_on = 1'b1;
    drain_pixels();
  endtask

  // random pixels under several random tint settings, with a full pause midway
  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      write_random_tints();
      push_random_pixels(30);
      drain_pixels();
      push_random_pixels(30);
      drain_pixels();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_pixels();
    test_tint_registers();
    test_raster_frame();
    test_back_to_back();
    test_output_hold();
    test_random_mix();

    drain_pixels();
    $display("%0d pixel requests sent, %0d results checked, %0d inside the disc",
             pixels_sent, pixels_checked, covered_seen);
    $display("%0d tint writes incl. unused index, full raster frame, stalls and holds",
             tint_writes);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* radial_falloff_sprite_pixel.f */
rtl/core/rfs_pkg.sv
rtl/core/rfs_dist.sv
rtl/core/rfs_root.sv
rtl/core/rfs_shade.sv
rtl/core/radial_falloff_sprite_pixel.sv
verif/tb_radial_falloff_sprite_pixel.sv
